FILE: hw/rtl/srtb_pkg.sv
// ----------------------------------------------------------------------------
// srtb_pkg
// shared types, constants and the sort order function for the sprite batcher
// ----------------------------------------------------------------------------
package srtb_pkg;

    localparam int MAX_SPRITES      = 64;
    localparam int IDX_W            = $clog2(MAX_SPRITES);
    localparam int CNT_W            = $clog2(MAX_SPRITES + 1);
    localparam int OUT_W            = 9;

    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_DEPTH_ASC = 2'd1;
    localparam logic [1:0] MODE_DEPTH_DSC = 2'd2;
    localparam logic [1:0] MODE_TEX_ASC   = 2'd3;

    typedef struct packed {
        logic signed [31:0] depth_key;
        logic [15:0]        sprite_tex;
        logic               last_sprite;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] batch_offset;
        logic [OUT_W-1:0] vertex_count;
        logic [15:0]      batch_texture;
        logic             last_batch;
        logic             sprites_dropped;
    } t_out;

    typedef struct packed {
        logic signed [31:0] depth;
        logic [15:0]        tex;
    } t_sprite;

    typedef struct packed {
        logic             load;
        logic             sort;
        logic             shift;
        logic             parity;
        logic [1:0]       mode;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

    // strict ordering: a goes before b
    function automatic logic goes_before(input logic [1:0] mode, input t_sprite a,
                                         input t_sprite b);
        logic res;
        case (mode)
            MODE_DEPTH_ASC: begin
                res = $signed(a.depth) < $signed(b.depth);
            end
            MODE_DEPTH_DSC: begin
                res = $signed(a.depth) > $signed(b.depth);
            end
            MODE_TEX_ASC: begin
                res = a.tex < b.tex;
            end
            default: begin
                res = 1'b0;
            end
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/srtb_cell.sv
// ----------------------------------------------------------------------------
// srtb_cell
// one slot of the sprite chain: load, odd-even compare-exchange and shift
// ----------------------------------------------------------------------------
module srtb_cell import srtb_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_index,
    input  t_sprite          i_new,
    input  t_sprite          i_prev,
    input  t_sprite          i_next,
    input  logic             i_next_before,
    output t_sprite          o_item,
    output logic             o_before
);

    t_sprite          r_item;
    t_sprite          n_item;
    logic [CNT_W-1:0] w_idx;
    logic             w_lo_active;
    logic             w_hi_active;

    assign w_idx    = CNT_W'(i_index);
    assign o_item   = r_item;
    assign o_before = goes_before(i_ctrl.mode, r_item, i_prev);

    // pair with the lower neighbor, and pair with the upper neighbor
    assign w_lo_active = i_ctrl.sort && (i_index != '0) && (i_index[0] != i_ctrl.parity)
                         && (w_idx < i_ctrl.count);
    assign w_hi_active = i_ctrl.sort && (i_index[0] == i_ctrl.parity)
                         && ((w_idx + CNT_W'(1)) < i_ctrl.count);

    always_comb begin
        n_item = r_item;
        if (i_ctrl.load && (w_idx == i_ctrl.count)) begin
            n_item = i_new;
        end else if (i_ctrl.shift) begin
            n_item = i_next;
        end else if (w_lo_active && o_before) begin
            n_item = i_prev;
        end else if (w_hi_active && i_next_before) begin
            n_item = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

FILE: hw/rtl/stable_sort_and_texture_batcher.sv
// ----------------------------------------------------------------------------
// stable_sort_and_texture_batcher
// stores sprites in a chain of cells, stable-sorts them by odd-even
// transposition and streams out one transaction per texture batch
// ----------------------------------------------------------------------------
// loading: one sprite per cycle into the cell chain
// after the last sprite of a frame: odd-even sort of the n stored sprites, then one
// chain shift per sprite; each batch is registered out as the scan passes its last
// sprite, while the output is not stalled; input is stalled during sort and scan
// synchronous active-low reset clears sprite count, drop flag, sort mode and valids
module stable_sort_and_texture_batcher import srtb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_phase;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_run_start;
    logic [CNT_W-1:0] r_run_len;
    logic             r_out_valid;
    t_out             r_out_data;

    t_cell_ctrl       w_ctrl;
    t_sprite          w_new;
    t_sprite          w_item   [MAX_SPRITES];
    logic             w_before [MAX_SPRITES];
    logic             w_in_acc;
    logic             w_full;
    logic             w_out_free;
    logic             w_adv;
    logic [CNT_W-1:0] w_pos_next;
    logic             w_end_frame;
    logic             w_end_run;
    logic [OUT_W-1:0] w_start9;
    logic [OUT_W-1:0] w_len9;

    assign o_in_stall  = (r_state != S_LOAD);
    assign w_in_acc    = i_in_valid && (r_state == S_LOAD);
    assign w_full      = (r_count == CNT_W'(MAX_SPRITES));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_adv       = (r_state == S_EMIT) && w_out_free;
    assign w_pos_next  = r_pos + CNT_W'(1);
    assign w_end_frame = (w_pos_next == r_count);
    assign w_end_run   = w_end_frame || (w_item[1].tex != w_item[0].tex);
    assign w_start9    = OUT_W'(r_run_start);
    assign w_len9      = OUT_W'(r_run_len) + OUT_W'(1);

    assign w_new.depth = i_in_data.depth_key;
    assign w_new.tex   = i_in_data.sprite_tex;

    assign w_ctrl.load   = w_in_acc && !w_full;
    assign w_ctrl.sort   = (r_state == S_SORT);
    assign w_ctrl.shift  = w_adv;
    assign w_ctrl.parity = r_phase[0];
    assign w_ctrl.mode   = r_mode;
    assign w_ctrl.count  = r_count;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SPRITES; gi++) begin : g_cell
            t_sprite w_prev;
            t_sprite w_next;
            logic    w_next_before;
            if (gi == 0) begin : g_first
                assign w_prev = w_item[gi];
            end else begin : g_mid_lo
                assign w_prev = w_item[gi-1];
            end
            if (gi == MAX_SPRITES - 1) begin : g_last
                assign w_next        = '0;
                assign w_next_before = 1'b0;
            end else begin : g_mid_hi
                assign w_next        = w_item[gi+1];
                assign w_next_before = w_before[gi+1];
            end
            srtb_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_index       (IDX_W'(gi)),
                .i_new         (w_new),
                .i_prev        (w_prev),
                .i_next        (w_next),
                .i_next_before (w_next_before),
                .o_item        (w_item[gi]),
                .o_before      (w_before[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= MODE_NONE;
            r_phase     <= '0;
            r_pos       <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_adv && w_end_run) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in_data.last_sprite) begin
                            r_state <= S_SORT;
                            r_phase <= '0;
                        end
                    end
                end
                S_SORT: begin
                    r_phase <= r_phase + CNT_W'(1);
                    if ((r_phase + CNT_W'(1)) >= r_count) begin
                        r_state     <= S_EMIT;
                        r_pos       <= '0;
                        r_run_start <= '0;
                        r_run_len   <= '0;
                    end
                end
                S_EMIT: begin
                    if (w_adv) begin
                        r_pos <= w_pos_next;
                        if (w_end_run) begin
                            r_run_start <= w_pos_next;
                            r_run_len   <= '0;
                        end else begin
                            r_run_len <= r_run_len + CNT_W'(1);
                        end
                        if (w_end_frame) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_end_run) begin
            r_out_data.batch_offset    <= (w_start9 << 2) + (w_start9 << 1);
            r_out_data.vertex_count    <= (w_len9 << 2) + (w_len9 << 1);
            r_out_data.batch_texture   <= w_item[0].tex;
            r_out_data.last_batch      <= w_end_frame;
            r_out_data.sprites_dropped <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPRITES))
        else $error("sprite count beyond store size");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count != '0) && (r_pos < r_count))
        else $error("scan position outside stored sprites");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("drop flag set with room in store");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_end_frame) |=> (r_state == S_LOAD) && o_out_valid
        && o_out_data.last_batch)
        else $error("frame end without final batch");

endmodule

FILE: tb/sv/srtb_batch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtb_batch_checker
// watches the sprite and batch channels, predicts the batches of each frame
// with its own stable insertion sort and run merge, and compares every batch
// transaction field by field against the oldest expected one
// ----------------------------------------------------------------------------
module srtb_batch_checker import srtb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out       i_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    output int         o_errors,
    output int         o_pending
);

    localparam int VERTS_PER_SPRITE = 6;
    localparam int REPORT_LIMIT     = 10;

    logic signed [31:0] depth_mem [MAX_SPRITES];
    logic [15:0]        tex_mem   [MAX_SPRITES];
    int                 sprite_cnt = 0;
    logic               dropped    = 1'b0;
    logic [1:0]         mode       = MODE_NONE;
    t_out               batch_q [$];
    int                 err_cnt    = 0;

    function automatic logic ahead_of(input int a, input int b);
        case (mode)
            MODE_DEPTH_ASC: return depth_mem[a] < depth_mem[b];
            MODE_DEPTH_DSC: return depth_mem[a] > depth_mem[b];
            MODE_TEX_ASC:   return tex_mem[a] < tex_mem[b];
            default:        return 1'b0;
        endcase
    endfunction

    task automatic close_frame();
        int   order [MAX_SPRITES];
        int   key;
        int   k;
        int   start;
        t_out b;
        for (int i = 0; i < sprite_cnt; i++) begin
            order[i] = i;
        end
        // stable insertion sort
        for (int i = 1; i < sprite_cnt; i++) begin
            key = order[i];
            k   = i;
            while (k > 0 && ahead_of(key, order[k-1])) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = key;
        end
        // merge neighbors with the same texture
        start = 0;
        for (int i = 1; i <= sprite_cnt; i++) begin
            if (i == sprite_cnt || tex_mem[order[i]] != tex_mem[order[start]]) begin
                b.batch_offset    = OUT_W'(start * VERTS_PER_SPRITE);
                b.vertex_count    = OUT_W'((i - start) * VERTS_PER_SPRITE);
                b.batch_texture   = tex_mem[order[start]];
                b.last_batch      = (i == sprite_cnt);
                b.sprites_dropped = dropped;
                batch_q = {batch_q, b};
                start = i;
            end
        end
        sprite_cnt = 0;
        dropped    = 1'b0;
    endtask

    task automatic take_sprite(input t_in s);
        if (sprite_cnt < MAX_SPRITES) begin
            depth_mem[sprite_cnt] = s.depth_key;
            tex_mem[sprite_cnt]   = s.sprite_tex;
            sprite_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (s.last_sprite) begin
            close_frame();
        end
    endtask

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_batch(input t_out got);
        t_out want;
        if (batch_q.size() == 0) begin
            report($sformatf("batch with none expected: offset %0d count %0d tex %h last %b drop %b",
                got.batch_offset, got.vertex_count, got.batch_texture, got.last_batch,
                got.sprites_dropped));
        end else begin
            want = batch_q.pop_front();
            if (got.batch_offset !== want.batch_offset
                    || got.vertex_count !== want.vertex_count
                    || got.batch_texture !== want.batch_texture
                    || got.last_batch !== want.last_batch
                    || got.sprites_dropped !== want.sprites_dropped) begin
                report($sformatf({"batch mismatch: expected offset %0d count %0d tex %h last %b ",
                    "drop %b, got offset %0d count %0d tex %h last %b drop %b"},
                    want.batch_offset, want.vertex_count, want.batch_texture, want.last_batch,
                    want.sprites_dropped, got.batch_offset, got.vertex_count,
                    got.batch_texture, got.last_batch, got.sprites_dropped));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sprite_cnt = 0;
            dropped    = 1'b0;
            mode       = MODE_NONE;
            batch_q.delete();
        end else begin
            if (i_cfg_we) begin
                mode = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                check_batch(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                take_sprite(i_in_data);
            end
        end
        o_pending <= batch_q.size();
        o_errors  <= err_cnt;
    end

endmodule

FILE: tb/sv/tb_stable_sort_and_texture_batcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sort_and_texture_batcher
// drives sprite frames in every sort mode, including full and overflowing
// stores, under changing idle and stall patterns and one long output hold-off;
// a checker beside the block predicts and compares the batch transactions
// ----------------------------------------------------------------------------
module tb_stable_sort_and_texture_batcher;
    import srtb_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int STYLE_POOL     = 0;
    localparam int STYLE_SAME     = 1;
    localparam int STYLE_DISTINCT = 2;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in        i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_wdata = MODE_NONE;

    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;
    int cycle_cnt  = 0;
    int mismatches;
    int pending;

    logic [31:0] mix_depth [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                   32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000};
    logic [15:0] mix_tex   [6] = '{16'h0001, 16'h0002, 16'h0003,
                                   16'h0001, 16'h0004, 16'h0004};
    logic [15:0] rank_tex  [6] = '{16'hFFFF, 16'h0005, 16'h0000,
                                   16'h0005, 16'hFFFF, 16'h0000};

    stable_sort_and_texture_batcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    srtb_batch_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (mismatches),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // output side: random stall, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_stable_sort_and_texture_batcher failed");
            $finish;
        end
    end

    task automatic send_sprite(input logic [31:0] depth, input logic [15:0] tex,
                               input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{depth_key: depth, sprite_tex: tex, last_sprite: last};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_mix(input bit by_tex);
        for (int i = 0; i < 6; i++) begin
            send_sprite(mix_depth[i], by_tex ? rank_tex[i] : mix_tex[i], i == 5);
        end
    endtask

    task automatic send_frame(input int n, input int style);
        logic [15:0] tex_pool   [3];
        logic [31:0] depth_pool [3];
        logic [31:0] depth;
        logic [15:0] tex;
        for (int j = 0; j < 3; j++) begin
            tex_pool[j]   = 16'($urandom_range(0, 65535));
            depth_pool[j] = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            depth = ($urandom_range(0, 2) == 0) ? depth_pool[$urandom_range(0, 2)] : $urandom;
            case (style)
                STYLE_SAME:     tex = tex_pool[0];
                STYLE_DISTINCT: tex = 16'hFFFF - 16'(i);
                default: begin
                    tex = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                      : tex_pool[$urandom_range(0, 2)];
                end
            endcase
            send_sprite(depth, tex, i == n - 1);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames
        write_mode(MODE_NONE);
        send_sprite(32'h7FFF_FFFF, 16'h0000, 1'b1);
        send_sprite(32'h8000_0000, 16'hFFFF, 1'b0);
        send_sprite(32'h0000_0000, 16'hFFFF, 1'b0);
        send_sprite(32'hFFFF_FFFF, 16'h1234, 1'b0);
        send_sprite(32'h0000_0001, 16'hFFFF, 1'b1);
        write_mode(MODE_DEPTH_ASC);
        send_mix(1'b0);
        write_mode(MODE_DEPTH_DSC);
        send_mix(1'b0);
        write_mode(MODE_TEX_ASC);
        send_mix(1'b1);

        // no idling, overflowing frame of distinct textures under a long output hold-off
        idle_pct  = 0;
        stall_pct = 0;
        write_mode(MODE_TEX_ASC);
        hold_req = 1'b1;
        send_frame(MAX_SPRITES + 2, STYLE_DISTINCT);
        send_frame($urandom_range(3, 6), STYLE_POOL);

        // idle sender
        idle_pct = 62;
        write_mode(MODE_NONE);
        send_frame(4, STYLE_SAME);
        send_frame($urandom_range(1, 6), STYLE_POOL);

        // stalling receiver
        idle_pct  = 0;
        stall_pct = 62;
        write_mode(MODE_DEPTH_ASC);
        repeat (2) send_frame($urandom_range(1, 6), STYLE_POOL);

        // both
        idle_pct  = 24;
        stall_pct = 24;
        write_mode(MODE_DEPTH_DSC);
        send_frame($urandom_range(1, 6), STYLE_POOL);
        repeat (2) begin
            write_mode(2'($urandom_range(0, 3)));
            send_frame($urandom_range(1, 6), STYLE_POOL);
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_stable_sort_and_texture_batcher passed");
        end else begin
            $display("tb_stable_sort_and_texture_batcher failed");
        end
        $finish;
    end

endmodule
